### sv/agsc_pkg.sv
// Shared types and constants for the audio glitch statistics counter.
`timescale 1ns / 1ps
package agsc_pkg;

    localparam int FRAC_BITS = 20;
    localparam int ITER_W    = 5;
    localparam int LOG_EXP_W = 6;
    localparam int LOG_W     = LOG_EXP_W + FRAC_BITS;
    localparam int MANT_W    = 32;
    localparam int NIBBLE    = 4;
    localparam int PROD_W    = LOG_W + 32;
    localparam int ROUND_POS = 35;
    localparam int SCORE_POS = 36;
    localparam int SCORE_W   = 21;

    localparam logic [31:0]        LN2_Q32    = 32'hB172_17F8;
    localparam logic [SCORE_W-1:0] SMOOTH_MAX = 21'h1F_FFFF;
    localparam logic [31:0]        WPR_RESET  = 32'd1024;

    localparam logic [1:0] MODE_UNDERRUN = 2'd0;
    localparam logic [1:0] MODE_OVERRUN  = 2'd1;
    localparam logic [1:0] MODE_WRITE    = 2'd2;
    localparam logic [1:0] MODE_FLUSH    = 2'd3;

    localparam logic [1:0] KIND_NORMAL  = 2'd0;
    localparam logic [1:0] KIND_PERFECT = 2'd1;
    localparam logic [1:0] KIND_INVALID = 2'd2;
    localparam logic [1:0] KIND_SUM_OVF = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] frame_count;
        logic [63:0] event_time;
    } agsc_in_t;

    typedef struct packed {
        logic               status;
        logic               reported;
        logic [31:0]        underruns;
        logic [31:0]        overruns;
        logic [31:0]        writes;
        logic [31:0]        written_count;
        logic [31:0]        lost_count;
        logic [63:0]        last_time;
        logic [SCORE_W-1:0] smoothness;
        logic [1:0]         smoothness_kind;
    } agsc_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_LOG,
        ST_SCALE,
        ST_ROUND,
        ST_DONE
    } agsc_state_t;

    typedef enum logic [1:0] {
        LG_IDLE,
        LG_NORM,
        LG_SQUARE,
        LG_DONE
    } agsc_lg_state_t;

endpackage

### sv/audio_glitch_stats_counter.sv
// Top level of the audio glitch statistics counter with report and smoothness score.
`timescale 1ns / 1ps
// Usage:
//   s_valid/s_ready/s_data carry one event beat (mode, frame_count, event_time).
//   m_valid/m_ready/m_data carry one result beat for every event beat.
//   cfg_valid/cfg_ready/cfg_data write writes_per_report; cfg_ready is always high.
// Sequencing and throughput:
//   An event that does not report goes from the idle state straight to the done
//   state. A report of normal kind passes the sum, log, scale and round states and
//   runs the two log2 units side by side, paced by the normalizer (one nibble or
//   bit per cycle) and the 20 serial squaring steps. A report of any other kind
//   goes from the sum state straight to the done state.
//   One event is in work at a time; s_ready is high only between events and
//   rises the cycle after the previous result loads the output register.
// Reset:
//   aresetn (synchronous, active low) clears all counters, the timestamp and
//   the output valid, and sets writes_per_report to 1024.
// Stall:
//   A finished result sits in the output register until taken; the next event
//   is accepted meanwhile, and its result holds in the core until the output
//   register frees up.
module audio_glitch_stats_counter import agsc_pkg::*; #(
    parameter int COUNT_WIDTH = 32,
    parameter int TIME_WIDTH  = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  agsc_in_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output agsc_out_t   m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    localparam int NW = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

    agsc_state_t            state_reg, state_next;
    logic [31:0]            wpr_reg;
    logic [COUNT_WIDTH-1:0] underrun_reg;
    logic [COUNT_WIDTH-1:0] overrun_reg;
    logic [COUNT_WIDTH-1:0] write_reg;
    logic [COUNT_WIDTH-1:0] written_reg;
    logic [COUNT_WIDTH-1:0] lost_reg;
    logic [TIME_WIDTH-1:0]  time_reg;
    logic [COUNT_WIDTH-1:0] op_lost_reg;
    logic [COUNT_WIDTH-1:0] op_wr_reg;
    logic [PROD_W-1:0]      prod_reg;
    agsc_out_t              res_reg;
    agsc_out_t              m_data_reg;
    logic                   m_valid_reg;

    logic                   s_fire;
    logic                   is_write;
    logic                   is_flush;
    logic [COUNT_WIDTH-1:0] ev_cnt;
    logic                   cnt_ovf;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic [COUNT_WIDTH-1:0] frm_acc;
    logic [NW:0]            frm_sum;
    logic                   frm_ovf;
    logic [COUNT_WIDTH-1:0] frm_new;
    logic                   thresh_hit;
    logic                   ev_ok;
    logic                   do_report;
    logic [COUNT_WIDTH-1:0] snap_writes;
    logic [COUNT_WIDTH-1:0] snap_written;
    logic [TIME_WIDTH-1:0]  snap_time;
    agsc_out_t              res_next;

    logic [COUNT_WIDTH:0]   sum_w;
    logic [1:0]             sum_kind;
    logic                   log_start;
    logic                   done_a;
    logic                   done_b;
    logic [LOG_W-1:0]       log_sum;
    logic [LOG_W-1:0]       log_lost;
    logic [LOG_W-1:0]       log_diff;
    logic [PROD_W:0]        prod_rnd;
    logic [SCORE_W+1:0]     score_raw;
    logic [SCORE_W-1:0]     score;
    logic                   load_out;

    // event arithmetic
    always_comb begin
        s_fire   = s_valid && s_ready;
        is_write = (s_data.mode == MODE_WRITE);
        is_flush = (s_data.mode == MODE_FLUSH);
        case (s_data.mode)
            MODE_UNDERRUN: ev_cnt = underrun_reg;
            MODE_OVERRUN:  ev_cnt = overrun_reg;
            default:       ev_cnt = write_reg;
        endcase
        cnt_ovf    = &ev_cnt;
        cnt_inc    = ev_cnt + COUNT_WIDTH'(1);
        frm_acc    = is_write ? written_reg : lost_reg;
        frm_sum    = (NW+1)'(frm_acc) + (NW+1)'(s_data.frame_count);
        frm_ovf    = |frm_sum[NW:COUNT_WIDTH];
        frm_new    = frm_sum[COUNT_WIDTH-1:0];
        thresh_hit = (NW'(cnt_inc) >= NW'(wpr_reg));
        ev_ok      = !cnt_ovf && !frm_ovf;
        do_report  = is_flush || (is_write && ev_ok && thresh_hit);

        snap_writes  = is_write ? cnt_inc : write_reg;
        snap_written = is_write ? frm_new : written_reg;
        snap_time    = is_write ? s_data.event_time[TIME_WIDTH-1:0] : time_reg;

        res_next        = '0;
        res_next.status = !is_flush && !ev_ok;
        if (do_report) begin
            res_next.reported      = 1'b1;
            res_next.underruns     = 32'(underrun_reg);
            res_next.overruns      = 32'(overrun_reg);
            res_next.writes        = 32'(snap_writes);
            res_next.written_count = 32'(snap_written);
            res_next.lost_count    = 32'(lost_reg);
            res_next.last_time     = 64'(snap_time);
        end
    end

    // score arithmetic
    always_comb begin
        sum_w = (COUNT_WIDTH+1)'(op_lost_reg) + (COUNT_WIDTH+1)'(op_wr_reg);
        if (op_lost_reg == '0 && op_wr_reg == '0) begin
            sum_kind = KIND_INVALID;
        end else if (op_lost_reg == '0) begin
            sum_kind = KIND_PERFECT;
        end else if (sum_w[COUNT_WIDTH]) begin
            sum_kind = KIND_SUM_OVF;
        end else begin
            sum_kind = KIND_NORMAL;
        end
        log_diff  = (log_sum > log_lost) ? (log_sum - log_lost) : '0;
        prod_rnd  = (PROD_W+1)'(prod_reg) + ((PROD_W+1)'(1) << ROUND_POS);
        score_raw = prod_rnd[PROD_W -: SCORE_W+2];
        score     = (|score_raw[SCORE_W+1:SCORE_W]) ? SMOOTH_MAX : score_raw[SCORE_W-1:0];
    end

    agsc_log2 #(
        .WIDTH(NW)
    ) u_log_sum (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (log_start),
        .x      (NW'(sum_w[COUNT_WIDTH-1:0])),
        .done   (done_a),
        .result (log_sum)
    );

    agsc_log2 #(
        .WIDTH(NW)
    ) u_log_lost (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (log_start),
        .x      (NW'(op_lost_reg)),
        .done   (done_b),
        .result (log_lost)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = do_report ? ST_SUM : ST_DONE;
            end
            ST_SUM: begin
                state_next = (sum_kind == KIND_NORMAL) ? ST_LOG : ST_DONE;
            end
            ST_LOG: begin
                if (done_a && done_b) state_next = ST_SCALE;
            end
            ST_SCALE: state_next = ST_ROUND;
            ST_ROUND: state_next = ST_DONE;
            ST_DONE: begin
                if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready   = (state_reg == ST_IDLE);
        log_start = (state_reg == ST_SUM) && (sum_kind == KIND_NORMAL);
        load_out  = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
        cfg_ready = 1'b1;
        m_valid   = m_valid_reg;
        m_data    = m_data_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            wpr_reg      <= WPR_RESET;
            underrun_reg <= '0;
            overrun_reg  <= '0;
            write_reg    <= '0;
            written_reg  <= '0;
            lost_reg     <= '0;
            time_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                wpr_reg <= cfg_data;
            end
            if (s_fire) begin
                if (do_report) begin
                    underrun_reg <= '0;
                    overrun_reg  <= '0;
                    write_reg    <= '0;
                    written_reg  <= '0;
                    lost_reg     <= '0;
                    time_reg     <= '0;
                end else begin
                    case (s_data.mode)
                        MODE_UNDERRUN: begin
                            underrun_reg <= cnt_inc;
                            if (!cnt_ovf) lost_reg <= frm_new;
                        end
                        MODE_OVERRUN: begin
                            overrun_reg <= cnt_inc;
                            if (!cnt_ovf) lost_reg <= frm_new;
                        end
                        MODE_WRITE: begin
                            write_reg <= cnt_inc;
                            if (!cnt_ovf) written_reg <= frm_new;
                            if (ev_ok) time_reg <= s_data.event_time[TIME_WIDTH-1:0];
                        end
                        default: begin
                        end
                    endcase
                end
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            res_reg     <= res_next;
            op_lost_reg <= lost_reg;
            op_wr_reg   <= snap_written;
        end
        if (state_reg == ST_SUM) begin
            res_reg.smoothness_kind <= sum_kind;
        end
        if (state_reg == ST_SCALE) begin
            prod_reg <= PROD_W'(log_diff) * PROD_W'(LN2_Q32);
        end
        if (state_reg == ST_ROUND) begin
            res_reg.smoothness <= score;
        end
        if (load_out) begin
            m_data_reg <= res_reg;
        end
    end

    a_report_no_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.status && m_data.reported))
        else $error("report carries overflow status");

    a_score_only_normal: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.smoothness_kind != KIND_NORMAL) |-> (m_data.smoothness == '0))
        else $error("smoothness set outside normal kind");

    a_quiet_snapshot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.reported) |->
            (m_data.writes == '0 && m_data.lost_count == '0 && m_data.last_time == '0
             && m_data.smoothness_kind == KIND_NORMAL))
        else $error("snapshot fields set without report");

    a_log_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        log_start |=> (state_reg == ST_LOG && !done_a && !done_b))
        else $error("log units did not start");

endmodule

### sv/agsc_log2.sv
// Digit-serial log2 unit: nibble/bit normalizer and bit-per-cycle squaring fraction.
`timescale 1ns / 1ps
module agsc_log2 import agsc_pkg::*; #(
    parameter int WIDTH = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] x,
    output logic             done,
    output logic [LOG_W-1:0] result
);

    localparam int SH_W = $clog2(WIDTH);

    agsc_lg_state_t       state_reg, state_next;
    logic [WIDTH-1:0]     x_reg;
    logic [SH_W-1:0]      sh_reg;
    logic [MANT_W-1:0]    m_reg;
    logic [FRAC_BITS-1:0] frac_reg;
    logic [ITER_W-1:0]    iter_reg;

    logic                 top_set;
    logic                 top_zero;
    logic [2*MANT_W-1:0]  sq;
    logic                 sq_hi;
    logic [LOG_EXP_W-1:0] exp_val;

    assign top_set  = x_reg[WIDTH-1];
    assign top_zero = (x_reg[WIDTH-1 -: NIBBLE] == '0);
    assign sq       = (2*MANT_W)'(m_reg) * (2*MANT_W)'(m_reg);
    assign sq_hi    = sq[2*MANT_W-1];
    assign exp_val  = LOG_EXP_W'(WIDTH - 1) - LOG_EXP_W'(sh_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            LG_IDLE: begin
                if (start) state_next = LG_NORM;
            end
            LG_NORM: begin
                if (top_set) state_next = LG_SQUARE;
            end
            LG_SQUARE: begin
                if (iter_reg == ITER_W'(FRAC_BITS - 1)) state_next = LG_DONE;
            end
            LG_DONE: begin
                if (start) state_next = LG_NORM;
            end
            default: state_next = LG_IDLE;
        endcase
    end

    always_comb begin
        done   = (state_reg == LG_DONE);
        result = {exp_val, frac_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LG_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            LG_IDLE, LG_DONE: begin
                if (start) begin
                    x_reg  <= x;
                    sh_reg <= '0;
                end
            end
            LG_NORM: begin
                if (top_set) begin
                    m_reg    <= x_reg[WIDTH-1 -: MANT_W];
                    iter_reg <= '0;
                end else if (top_zero) begin
                    x_reg  <= x_reg << NIBBLE;
                    sh_reg <= sh_reg + SH_W'(NIBBLE);
                end else begin
                    x_reg  <= x_reg << 1;
                    sh_reg <= sh_reg + SH_W'(1);
                end
            end
            LG_SQUARE: begin
                m_reg    <= sq_hi ? sq[2*MANT_W-1 -: MANT_W] : sq[2*MANT_W-2 -: MANT_W];
                frac_reg <= {frac_reg[FRAC_BITS-2:0], sq_hi};
                iter_reg <= iter_reg + ITER_W'(1);
            end
            default: begin
            end
        endcase
    end

endmodule
